// ===== src/bts_pkg.sv =====
// Package with shared types and constants of the bilinear texture sampler.
package bts_pkg;
  localparam int CoordW = 18;
  localparam int ChanW = 16;
  localparam int AddrW = 16;
  localparam int CfgIdxW = 1;
  localparam int CfgDataW = 9;
  localparam logic [CfgIdxW-1:0] RegWidth = 1'b0;
  localparam logic [CfgIdxW-1:0] RegHeight = 1'b1;
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdSample = 1'b1;
  localparam logic [16:0] OneQ16 = 17'h10000;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;
endpackage

// ===== src/bts_in_if.sv =====
// Interface of the input channel carrying write and sample transactions.
interface bts_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic [bts_pkg::AddrW-1:0] texel_addr;
  logic [bts_pkg::ChanW-1:0] texel_red;
  logic [bts_pkg::ChanW-1:0] texel_green;
  logic [bts_pkg::ChanW-1:0] texel_blue;
  logic signed [bts_pkg::CoordW-1:0] coord_x;
  logic signed [bts_pkg::CoordW-1:0] coord_y;
  modport source (output valid, cmd, texel_addr, texel_red, texel_green, texel_blue,
                  coord_x, coord_y, input ready);
  modport sink (input valid, cmd, texel_addr, texel_red, texel_green, texel_blue,
                coord_x, coord_y, output ready);
endinterface

// ===== src/bts_out_if.sv =====
// Interface of the result channel carrying filtered colors.
interface bts_out_if;
  logic valid;
  logic ready;
  logic [bts_pkg::ChanW-1:0] sample_red;
  logic [bts_pkg::ChanW-1:0] sample_green;
  logic [bts_pkg::ChanW-1:0] sample_blue;
  modport source (output valid, sample_red, sample_green, sample_blue, input ready);
  modport sink (input valid, sample_red, sample_green, sample_blue, output ready);
endinterface

// ===== src/bilinear_texture_sampler_unit.sv =====
// Top level of the bilinear texture sampler with texel store and lerp sequencer.
//
// channel  direction  contents
// in       sink       cmd, texel_addr, texel_red/green/blue, coord_x, coord_y
// out      source     sample_red, sample_green, sample_blue
// cfg      write      cfg_we, cfg_idx, cfg_data (image_width, image_height)
//
// A write transaction is stored when accepted and leaves the unit idle. A sample runs
// from acceptance through these steps in order: scaling the coordinates on the shared
// multiplier, the four pipelined store reads, nine lerps on the multiplier plus one
// channel step per channel, loading the output register and the return to idle. The
// store has one read port and the multiplier is shared; ready is low outside idle.
// Reset is synchronous and active low; the store itself is not cleared.
// A finished result waits in the output register; a following sample holds before its
// result is loaded until the waiting one is taken.
module bilinear_texture_sampler_unit #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [bts_pkg::CfgIdxW-1:0] cfg_idx,
  input  logic [bts_pkg::CfgDataW-1:0] cfg_data,
  bts_in_if.sink in_ch,
  bts_out_if.source out_ch
);
  localparam int DimW = $clog2(((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT) + 1);
  localparam int Depth = 65536;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCALE = 7'b0000010,
    S_FETCH = 7'b0000100,
    S_LERPA = 7'b0001000,
    S_LERPB = 7'b0010000,
    S_NEXT  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [bts_pkg::CfgDataW-1:0] width_r, height_r;
  logic [DimW-1:0] w_eff, h_eff;
  bts_pkg::rgb_t mem [Depth];
  bts_pkg::rgb_t rd_data_r;
  bts_pkg::rgb_t tex_r [4];
  bts_pkg::rgb_t res_r;
  bts_pkg::rgb_t out_r;
  logic [16:0] xc_r, yc_r;
  logic [15:0] x0_r, y0_r, x1_r, y1_r, fx_r, fy_r;
  logic [2:0] cnt_r;
  logic [1:0] ch_r, lrp_r;
  logic [15:0] top_r, bot_r;
  logic out_valid_r;
  logic [15:0] rd_addr;
  logic [33:0] prod;
  logic [16:0] mul_a;
  logic [16:0] mul_b;
  logic [32:0] acc_r;
  logic [16:0] xc_in, yc_in;
  logic [15:0] ta, tb;

  function automatic logic [16:0] clamp_c(input logic signed [17:0] v);
    if (v[17]) return 17'd0;
    else if (v > 18'sd65536) return bts_pkg::OneQ16;
    else return v[16:0];
  endfunction

  function automatic logic [15:0] chan(input bts_pkg::rgb_t t, input logic [1:0] c);
    case (c)
      2'd0: return t.red;
      2'd1: return t.green;
      default: return t.blue;
    endcase
  endfunction

  always_comb begin
    if (width_r == '0) w_eff = DimW'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = DimW'(MAX_WIDTH);
    else w_eff = DimW'(width_r);
    if (height_r == '0) h_eff = DimW'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = DimW'(MAX_HEIGHT);
    else h_eff = DimW'(height_r);
  end

  assign xc_in = clamp_c(in_ch.coord_x);
  assign yc_in = clamp_c(in_ch.coord_y);

  // Address of texel cnt: bit 0 picks column, bit 1 picks row.
  always_comb begin
    logic [15:0] col, row;
    logic [31:0] a;
    col = cnt_r[0] ? x1_r : x0_r;
    row = cnt_r[1] ? y1_r : y0_r;
    a = 32'(row) * 32'(w_eff) + 32'(col);
    rd_addr = a[15:0];
  end

  // Shared multiplier operands.
  always_comb begin
    case (lrp_r)
      2'd2: begin ta = top_r; tb = bot_r; end
      2'd1: begin ta = chan(tex_r[2], ch_r); tb = chan(tex_r[3], ch_r); end
      default: begin ta = chan(tex_r[0], ch_r); tb = chan(tex_r[1], ch_r); end
    endcase
    mul_a = 17'(ta);
    mul_b = bts_pkg::OneQ16 - 17'((lrp_r == 2'd2) ? fy_r : fx_r);
    if (state_r == S_SCALE) begin
      mul_a = cnt_r[0] ? yc_r : xc_r;
      mul_b = cnt_r[0] ? 17'(h_eff - DimW'(1)) : 17'(w_eff - DimW'(1));
    end else if (state_r == S_LERPB) begin
      mul_a = 17'(tb);
      mul_b = 17'((lrp_r == 2'd2) ? fy_r : fx_r);
    end
    prod = mul_a * mul_b;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_ch.valid && in_ch.ready && in_ch.cmd == bts_pkg::CmdSample)
                 state_nxt = S_SCALE;
      S_SCALE: if (cnt_r[0]) state_nxt = S_FETCH;
      S_FETCH: if (cnt_r == 3'd4) state_nxt = S_LERPA;
      S_LERPA: state_nxt = S_LERPB;
      S_LERPB: state_nxt = (lrp_r == 2'd2) ? S_NEXT : S_LERPA;
      S_NEXT:  state_nxt = (ch_r == 2'd2) ? S_DONE : S_LERPA;
      S_DONE:  if (!out_valid_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      width_r <= bts_pkg::CfgDataW'(1);
      height_r <= bts_pkg::CfgDataW'(1);
      out_valid_r <= 1'b0;
      cnt_r <= '0;
      ch_r <= '0;
      lrp_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_idx == bts_pkg::RegWidth) width_r <= cfg_data;
        else if (cfg_idx == bts_pkg::RegHeight) height_r <= cfg_data;
      end
      if (out_ch.valid && out_ch.ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          ch_r <= '0;
          lrp_r <= '0;
        end
        S_SCALE: cnt_r <= cnt_r[0] ? 3'd0 : 3'd1;
        S_FETCH: cnt_r <= cnt_r + 3'd1;
        S_LERPB: lrp_r <= (lrp_r == 2'd2) ? 2'd0 : lrp_r + 2'd1;
        S_NEXT: ch_r <= ch_r + 2'd1;
        S_DONE: if (!out_valid_r) out_valid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload and store.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid && in_ch.ready) begin
      if (in_ch.cmd == bts_pkg::CmdWrite)
        mem[in_ch.texel_addr] <= '{in_ch.texel_red, in_ch.texel_green, in_ch.texel_blue};
      xc_r <= xc_in;
      yc_r <= yc_in;
    end
    rd_data_r <= mem[rd_addr];
    if (state_r == S_SCALE) begin
      if (!cnt_r[0]) begin
        x0_r <= prod[31:16];
        fx_r <= prod[15:0];
        x1_r <= (17'(prod[31:16]) + 17'd1 < 17'(w_eff)) ? prod[31:16] + 16'd1
                                                       : 16'(w_eff - DimW'(1));
      end else begin
        y0_r <= prod[31:16];
        fy_r <= prod[15:0];
        y1_r <= (17'(prod[31:16]) + 17'd1 < 17'(h_eff)) ? prod[31:16] + 16'd1
                                                       : 16'(h_eff - DimW'(1));
      end
    end
    if (state_r == S_FETCH && cnt_r != 3'd0) tex_r[cnt_r[1:0] - 2'd1] <= rd_data_r;
    if (state_r == S_LERPA) acc_r <= prod[32:0];
    if (state_r == S_LERPB) begin
      logic [32:0] s;
      s = acc_r + prod[32:0];
      case (lrp_r)
        2'd0: top_r <= s[31:16];
        2'd1: bot_r <= s[31:16];
        default: begin
          case (ch_r)
            2'd0: res_r.red <= s[31:16];
            2'd1: res_r.green <= s[31:16];
            default: res_r.blue <= s[31:16];
          endcase
        end
      endcase
    end
    if (state_r == S_DONE && !out_valid_r) out_r <= res_r;
  end

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.sample_red = out_r.red;
  assign out_ch.sample_green = out_r.green;
  assign out_ch.sample_blue = out_r.blue;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.cmd == bts_pkg::CmdSample |=> state_r == S_SCALE)
    else $error("sample did not start");
  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE) else $error("stray result");
endmodule
